// File: src/emspi_pkg.sv
package emspi_pkg;

	// input event codes
	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_CS    = 2'd1;
	localparam logic [1:0] OP_RELAY = 2'd2;

	// transfer actions
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_START2 = 2'd1;
	localparam logic [1:0] ACT_START4 = 2'd2;
	localparam logic [1:0] ACT_STOP   = 2'd3;

	// register addresses
	localparam logic [11:0] ADDR_DSPCFG  = 12'h020;
	localparam logic [11:0] ADDR_IRMS    = 12'h202;
	localparam logic [11:0] ADDR_VRMS    = 12'h203;
	localparam logic [11:0] ADDR_WATT    = 12'h204;
	localparam logic [11:0] ADDR_VA      = 12'h206;
	localparam logic [11:0] ADDR_VAR     = 12'h207;
	localparam logic [11:0] ADDR_VERSION = 12'h242;
	localparam logic [11:0] ADDR_RUN     = 12'h480;
	localparam logic [11:0] ADDR_GAIN    = 12'h4B9;

	localparam logic [31:0] VERSION_WORD = 32'h0009_153A;
	localparam logic [31:0] CS_LOAD_WORD = 32'hFFFF_0000;

	// measurement presets with relay on, and voltage with relay off
	localparam logic [17:0] PRE_WATT     = 18'h3FFE1;
	localparam logic [11:0] PRE_VAR      = 12'hAB2;
	localparam logic [17:0] PRE_VA       = 18'h3FFFF;
	localparam logic [20:0] PRE_IRMS     = 21'h1FEEF4;
	localparam logic [24:0] PRE_VRMS     = 25'h0FFEFA5;
	localparam logic [24:0] PRE_VRMS_OFF = 25'h1090000;

	// index strides per measurement slot
	localparam logic [2:0] STRIDE_WATT = 3'd3;
	localparam logic [2:0] STRIDE_VAR  = 3'd5;
	localparam logic [2:0] STRIDE_VA   = 3'd7;
	localparam logic [2:0] STRIDE_IRMS = 3'd5;
	localparam logic [2:0] STRIDE_VRMS = 3'd7;

	// measurement slots
	localparam int SLOT_WATT = 0;
	localparam int SLOT_VAR  = 1;
	localparam int SLOT_VA   = 2;
	localparam int SLOT_IRMS = 3;
	localparam int SLOT_VRMS = 4;
	localparam int NUM_SLOTS = 5;

	localparam logic [17:0] TAB_WATT [8] = '{18'h3FCE1, 18'h3FDE1, 18'h3F9E1, 18'h3F2E1,
		18'h3FAE1, 18'h3FBE1, 18'h3F6E1, 18'h3F4E1};
	localparam logic [11:0] TAB_VAR [8] = '{12'hAB2, 12'hAC2, 12'hA22, 12'hA52,
		12'hBB2, 12'hA92, 12'h9B2, 12'hAF2};
	localparam logic [17:0] TAB_VA [8] = '{18'h3FFFF, 18'h3FDFF, 18'h3FCFF, 18'h3F3FF,
		18'h3F1FF, 18'h3FBFF, 18'h3F9FF, 18'h3F8FF};
	localparam logic [20:0] TAB_IRMS [8] = '{21'h1FAEF4, 21'h1F7EF4, 21'h1F1EF4, 21'h1F2EF4,
		21'h1FCEF4, 21'h1FAEF4, 21'h1F8EF4, 21'h1FDEF4};
	localparam logic [24:0] TAB_VRMS [8] = '{25'h0FEEFA5, 25'h0FFFFA5, 25'h0FFCFA5, 25'h0FBEFA5,
		25'h0FDEFA5, 25'h0F2EFA5, 25'h0FD1FA5, 25'h0FFEFA5};

	typedef enum logic [1:0] {
		PH_CMD   = 2'd0,
		PH_WDATA = 2'd1,
		PH_REND  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		TGT_RUN  = 2'd0,
		TGT_GAIN = 2'd1,
		TGT_DSP  = 2'd2,
		TGT_VER  = 2'd3
	} target_t;

endpackage

// File: src/energy_meter_spi_register_slave.sv
// channel  | handshake             | payload
// ---------+-----------------------+----------------------------------------------------
// input    | in_valid / in_ready   | op, frame_word, frame_bytes, pin_level
// output   | out_valid / out_ready | transfer_action, miso_word, miso_load, relay_state
//
// one transaction per cycle sustained while out_ready stays high; a result moves from the
// input register into the output register, where it waits until out_ready takes it
// (input register, then decode and register update into the output register)
// arst_n clears the handshake state, the phase, the register file and the table indexes
// and loads the measurement presets at once; no clearing pass follows reset
// a stall on the output holds the result register; the input register still takes one
// more transaction, and in_ready drops only when both stages are full and out_ready is low
module energy_meter_spi_register_slave #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] frame_word,
	input  logic [2:0]  frame_bytes,
	input  logic        pin_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  transfer_action,
	output logic [31:0] miso_word,
	output logic        miso_load,
	output logic        relay_state
);

	// index width and the width of index plus stride before the wrap
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = IW + 4;

	// wrap index plus stride back below the table depth; at most eight subtracts
	function automatic logic [IW-1:0] idx_step(input logic [IW-1:0] idx,
		input logic [2:0] stride);
		logic [SW-1:0] s;
		s = SW'(idx) + SW'(stride);
		for (int k = 0; k < 8; k++) begin
			if (s >= SW'(TABLE_DEPTH)) begin
				s = s - SW'(TABLE_DEPTH);
			end
		end
		return s[IW-1:0];
	endfunction

	// the eight-entry tables are addressed by the low three index bits
	function automatic logic [2:0] tab_sel(input logic [IW-1:0] idx);
		logic [SW-1:0] t;
		t = SW'(idx);
		return t[2:0];
	endfunction

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [31:0] word_s1;
	logic [2:0]  bytes_s1;
	logic        level_s1;

	// result stage
	logic        valid_s2;
	logic [1:0]  action_s2;
	logic [31:0] miso_s2;
	logic        load_s2;
	logic        relay_s2;

	// block state
	emspi_pkg::phase_t  phase_q, phase_d;
	emspi_pkg::target_t target_q, target_d;
	logic [15:0] run_q, run_d;
	logic [15:0] gain_q, gain_d;
	logic [31:0] dsp_q, dsp_d;
	logic [17:0] watt_q, watt_d;
	logic [11:0] var_q, var_d;
	logic [17:0] va_q, va_d;
	logic [20:0] irms_q, irms_d;
	logic [24:0] vrms_q, vrms_d;
	logic [IW-1:0] idx_q [emspi_pkg::NUM_SLOTS];
	logic [IW-1:0] idx_d [emspi_pkg::NUM_SLOTS];
	logic relay_q, relay_d;

	// step results
	logic [1:0]  action_d;
	logic [31:0] miso_d;
	logic        load_d;

	logic        advance;
	logic        step;

	// the result register frees when empty or taken; the input register moves on then
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	assign out_valid       = valid_s2;
	assign transfer_action = action_s2;
	assign miso_word       = miso_s2;
	assign miso_load       = load_s2;
	assign relay_state     = relay_s2;

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op;
			word_s1  <= frame_word;
			bytes_s1 <= frame_bytes;
			level_s1 <= pin_level;
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (step) begin
			action_s2 <= action_d;
			miso_s2   <= load_d ? miso_d : 32'd0;
			load_s2   <= load_d;
			relay_s2  <= relay_d;
		end
	end

	// state registers, updated once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= emspi_pkg::PH_CMD;
			target_q <= emspi_pkg::TGT_RUN;
			run_q    <= '0;
			gain_q   <= '0;
			dsp_q    <= '0;
			watt_q   <= emspi_pkg::PRE_WATT;
			var_q    <= emspi_pkg::PRE_VAR;
			va_q     <= emspi_pkg::PRE_VA;
			irms_q   <= emspi_pkg::PRE_IRMS;
			vrms_q   <= emspi_pkg::PRE_VRMS;
			for (int i = 0; i < emspi_pkg::NUM_SLOTS; i++) begin
				idx_q[i] <= '0;
			end
			relay_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			target_q <= target_d;
			run_q    <= run_d;
			gain_q   <= gain_d;
			dsp_q    <= dsp_d;
			watt_q   <= watt_d;
			var_q    <= var_d;
			va_q     <= va_d;
			irms_q   <= irms_d;
			vrms_q   <= vrms_d;
			for (int i = 0; i < emspi_pkg::NUM_SLOTS; i++) begin
				idx_q[i] <= idx_d[i];
			end
			relay_q  <= relay_d;
		end
	end

	// decode of one transaction: next state and result
	always_comb begin
		logic        sel;
		logic [15:0] hi;
		logic [11:0] addr;
		logic        rd;
		logic        known;
		logic        wide;
		logic        writable;
		emspi_pkg::target_t tgt;

		phase_d  = phase_q;
		target_d = target_q;
		run_d    = run_q;
		gain_d   = gain_q;
		dsp_d    = dsp_q;
		watt_d   = watt_q;
		var_d    = var_q;
		va_d     = va_q;
		irms_d   = irms_q;
		vrms_d   = vrms_q;
		for (int i = 0; i < emspi_pkg::NUM_SLOTS; i++) begin
			idx_d[i] = idx_q[i];
		end
		relay_d  = relay_q;
		action_d = emspi_pkg::ACT_NONE;
		miso_d   = 32'd0;
		load_d   = 1'b0;

		// chip select is active low
		sel      = !level_s1;
		hi       = word_s1[31:16];
		addr     = hi[15:4];
		rd       = hi[3];
		known    = 1'b1;
		wide     = 1'b1;
		writable = 1'b0;
		tgt      = emspi_pkg::TGT_RUN;

		case (op_s1)
			emspi_pkg::OP_CS: begin
				if (sel) begin
					miso_d   = emspi_pkg::CS_LOAD_WORD;
					load_d   = 1'b1;
					action_d = emspi_pkg::ACT_START2;
				end else begin
					action_d = emspi_pkg::ACT_STOP;
				end
			end
			emspi_pkg::OP_RELAY: begin
				relay_d = level_s1;
				watt_d  = level_s1 ? emspi_pkg::PRE_WATT : '0;
				var_d   = level_s1 ? emspi_pkg::PRE_VAR : '0;
				va_d    = level_s1 ? emspi_pkg::PRE_VA : '0;
				irms_d  = level_s1 ? emspi_pkg::PRE_IRMS : '0;
				vrms_d  = level_s1 ? emspi_pkg::PRE_VRMS : emspi_pkg::PRE_VRMS_OFF;
			end
			emspi_pkg::OP_FRAME: begin
				// empty frames are dropped
				if (bytes_s1 != 3'd0) begin
					case (phase_q)
						emspi_pkg::PH_REND: begin
							phase_d = emspi_pkg::PH_CMD;
							if (sel) begin
								action_d = emspi_pkg::ACT_START2;
							end
						end
						emspi_pkg::PH_WDATA: begin
							phase_d = emspi_pkg::PH_CMD;
							// data for the version word is swallowed
							if (target_q != emspi_pkg::TGT_VER) begin
								case (target_q)
									emspi_pkg::TGT_RUN:  run_d  = hi;
									emspi_pkg::TGT_GAIN: gain_d = hi;
									default:             dsp_d  = word_s1;
								endcase
								if (sel) begin
									action_d = emspi_pkg::ACT_START2;
								end
							end
						end
						default: begin
							// command frame; the unused phase code lands here too
							case (addr)
								emspi_pkg::ADDR_RUN: begin
									wide = 1'b0; writable = 1'b1;
									tgt = emspi_pkg::TGT_RUN;
									miso_d = {run_q, 16'd0};
								end
								emspi_pkg::ADDR_GAIN: begin
									wide = 1'b0; writable = 1'b1;
									tgt = emspi_pkg::TGT_GAIN;
									miso_d = {gain_q, 16'd0};
								end
								emspi_pkg::ADDR_DSPCFG: begin
									writable = 1'b1;
									tgt = emspi_pkg::TGT_DSP;
									miso_d = dsp_q;
								end
								emspi_pkg::ADDR_VERSION: begin
									writable = 1'b1;
									tgt = emspi_pkg::TGT_VER;
									miso_d = emspi_pkg::VERSION_WORD;
								end
								// measurement reads return the value, then reload and step
								emspi_pkg::ADDR_WATT: begin
									if (rd) begin
										miso_d = 32'(watt_q);
										watt_d = relay_q ?
											emspi_pkg::TAB_WATT[tab_sel(idx_q[emspi_pkg::SLOT_WATT])] : '0;
										idx_d[emspi_pkg::SLOT_WATT] =
											idx_step(idx_q[emspi_pkg::SLOT_WATT], emspi_pkg::STRIDE_WATT);
									end
								end
								emspi_pkg::ADDR_VAR: begin
									if (rd) begin
										miso_d = 32'(var_q);
										var_d = relay_q ?
											emspi_pkg::TAB_VAR[tab_sel(idx_q[emspi_pkg::SLOT_VAR])] : '0;
										idx_d[emspi_pkg::SLOT_VAR] =
											idx_step(idx_q[emspi_pkg::SLOT_VAR], emspi_pkg::STRIDE_VAR);
									end
								end
								emspi_pkg::ADDR_VA: begin
									if (rd) begin
										miso_d = 32'(va_q);
										va_d = relay_q ?
											emspi_pkg::TAB_VA[tab_sel(idx_q[emspi_pkg::SLOT_VA])] : '0;
										idx_d[emspi_pkg::SLOT_VA] =
											idx_step(idx_q[emspi_pkg::SLOT_VA], emspi_pkg::STRIDE_VA);
									end
								end
								emspi_pkg::ADDR_IRMS: begin
									if (rd) begin
										miso_d = 32'(irms_q);
										irms_d = relay_q ?
											emspi_pkg::TAB_IRMS[tab_sel(idx_q[emspi_pkg::SLOT_IRMS])] : '0;
										idx_d[emspi_pkg::SLOT_IRMS] =
											idx_step(idx_q[emspi_pkg::SLOT_IRMS], emspi_pkg::STRIDE_IRMS);
									end
								end
								emspi_pkg::ADDR_VRMS: begin
									// voltage reload ignores the relay
									if (rd) begin
										miso_d = 32'(vrms_q);
										vrms_d = emspi_pkg::TAB_VRMS[tab_sel(idx_q[emspi_pkg::SLOT_VRMS])];
										idx_d[emspi_pkg::SLOT_VRMS] =
											idx_step(idx_q[emspi_pkg::SLOT_VRMS], emspi_pkg::STRIDE_VRMS);
									end
								end
								default: begin
									known = 1'b0;
								end
							endcase

							if (known && rd) begin
								// read word loads even when deselected
								load_d = 1'b1;
								if (sel) begin
									phase_d  = emspi_pkg::PH_REND;
									action_d = wide ? emspi_pkg::ACT_START4 : emspi_pkg::ACT_START2;
								end
							end else if (known && writable) begin
								// data transfer starts whatever the chip select
								phase_d  = emspi_pkg::PH_WDATA;
								target_d = tgt;
								action_d = wide ? emspi_pkg::ACT_START4 : emspi_pkg::ACT_START2;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// an unloaded result carries a zero word
	a_miso_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !load_s2) |-> (miso_s2 == 32'd0))
		else $error("miso word not zero without load");

	// the shown relay flag is the flag the block holds after that step
	a_relay_track: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (relay_s2 == relay_q))
		else $error("relay state out of step with relay flag");

	// a 4-byte transfer start always leaves a transfer pending
	a_wide_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (action_s2 == emspi_pkg::ACT_START4)) |-> (phase_q != emspi_pkg::PH_CMD))
		else $error("4-byte start without pending phase");

	// a processed transaction always lands in the result register
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed transaction lost");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

	// event code that the slave does not decode
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one expected result transaction, one field per output port
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] miso;
		logic        load;
		logic        relay;
	} meter_result_t;

	// register model of the metering slave plus the queue of results it predicts
	class meter_scoreboard;
		emspi_pkg::phase_t  phase;
		emspi_pkg::target_t target;
		logic [15:0]   run_word;
		logic [15:0]   gain_word;
		logic [31:0]   dsp_word;
		logic [31:0]   meas [emspi_pkg::NUM_SLOTS];
		logic [2:0]    tab_pos [emspi_pkg::NUM_SLOTS];
		logic          relay;
		meter_result_t expected_q [$];
		int            errors;

		function new();
			phase = emspi_pkg::PH_CMD;
			target = emspi_pkg::TGT_RUN;
			run_word = '0;
			gain_word = '0;
			dsp_word = '0;
			relay = 1'b0;
			errors = 0;
			for (int i = 0; i < emspi_pkg::NUM_SLOTS; i++) tab_pos[i] = '0;
			load_presets(1'b1);
		endfunction

		// relay events force fixed measurement values; voltage has its own off value
		function void load_presets(logic on);
			if (on) begin
				meas[emspi_pkg::SLOT_WATT] = 32'(emspi_pkg::PRE_WATT);
				meas[emspi_pkg::SLOT_VAR]  = 32'(emspi_pkg::PRE_VAR);
				meas[emspi_pkg::SLOT_VA]   = 32'(emspi_pkg::PRE_VA);
				meas[emspi_pkg::SLOT_IRMS] = 32'(emspi_pkg::PRE_IRMS);
				meas[emspi_pkg::SLOT_VRMS] = 32'(emspi_pkg::PRE_VRMS);
			end else begin
				meas[emspi_pkg::SLOT_WATT] = '0;
				meas[emspi_pkg::SLOT_VAR]  = '0;
				meas[emspi_pkg::SLOT_VA]   = '0;
				meas[emspi_pkg::SLOT_IRMS] = '0;
				meas[emspi_pkg::SLOT_VRMS] = 32'(emspi_pkg::PRE_VRMS_OFF);
			end
		endfunction

		// hand out the present reading, then reload it from the table and step the index
		function logic [31:0] take_reading(int slot, logic [2:0] stride, logic gated);
			logic [31:0] now;
			logic [31:0] fresh;
			logic [2:0]  idx;
			now = meas[slot];
			idx = tab_pos[slot];
			case (slot)
				emspi_pkg::SLOT_WATT: fresh = 32'(emspi_pkg::TAB_WATT[idx]);
				emspi_pkg::SLOT_VAR:  fresh = 32'(emspi_pkg::TAB_VAR[idx]);
				emspi_pkg::SLOT_VA:   fresh = 32'(emspi_pkg::TAB_VA[idx]);
				emspi_pkg::SLOT_IRMS: fresh = 32'(emspi_pkg::TAB_IRMS[idx]);
				default:              fresh = 32'(emspi_pkg::TAB_VRMS[idx]);
			endcase
			meas[slot] = (gated && !relay) ? 32'h0 : fresh;
			tab_pos[slot] = idx + stride;
			return now;
		endfunction

		function void note_event(logic [1:0] op_c, logic [31:0] word, logic [2:0] nbytes,
				logic level);
			meter_result_t r;
			logic [15:0]   hi;
			logic [11:0]   addr;
			logic          rd;
			logic          known;
			logic          wide;
			logic          writable;
			logic          sel;
			emspi_pkg::target_t tgt;
			r = '0;
			sel = !level;
			hi = word[31:16];
			case (op_c)
				emspi_pkg::OP_CS: begin
					if (sel) begin
						r.action = emspi_pkg::ACT_START2;
						r.miso = emspi_pkg::CS_LOAD_WORD;
						r.load = 1'b1;
					end else begin
						r.action = emspi_pkg::ACT_STOP;
					end
				end
				emspi_pkg::OP_RELAY: begin
					relay = level;
					load_presets(level);
				end
				emspi_pkg::OP_FRAME: begin
					if (nbytes != 3'd0) begin
						if (phase == emspi_pkg::PH_REND) begin
							phase = emspi_pkg::PH_CMD;
							if (sel) r.action = emspi_pkg::ACT_START2;
						end else if (phase == emspi_pkg::PH_WDATA) begin
							phase = emspi_pkg::PH_CMD;
							if (target != emspi_pkg::TGT_VER) begin
								case (target)
									emspi_pkg::TGT_RUN:  run_word = hi;
									emspi_pkg::TGT_GAIN: gain_word = hi;
									default:             dsp_word = word;
								endcase
								if (sel) r.action = emspi_pkg::ACT_START2;
							end
						end else begin
							addr = hi[15:4];
							rd = hi[3];
							known = 1'b1;
							wide = 1'b1;
							writable = 1'b0;
							tgt = emspi_pkg::TGT_RUN;
							case (addr)
								emspi_pkg::ADDR_RUN: begin
									wide = 1'b0;
									writable = 1'b1;
									tgt = emspi_pkg::TGT_RUN;
									r.miso = {run_word, 16'h0};
								end
								emspi_pkg::ADDR_GAIN: begin
									wide = 1'b0;
									writable = 1'b1;
									tgt = emspi_pkg::TGT_GAIN;
									r.miso = {gain_word, 16'h0};
								end
								emspi_pkg::ADDR_DSPCFG: begin
									writable = 1'b1;
									tgt = emspi_pkg::TGT_DSP;
									r.miso = dsp_word;
								end
								emspi_pkg::ADDR_VERSION: begin
									writable = 1'b1;
									tgt = emspi_pkg::TGT_VER;
									r.miso = emspi_pkg::VERSION_WORD;
								end
								emspi_pkg::ADDR_WATT: if (rd) r.miso = take_reading(
									emspi_pkg::SLOT_WATT, emspi_pkg::STRIDE_WATT, 1'b1);
								emspi_pkg::ADDR_VAR:  if (rd) r.miso = take_reading(
									emspi_pkg::SLOT_VAR, emspi_pkg::STRIDE_VAR, 1'b1);
								emspi_pkg::ADDR_VA:   if (rd) r.miso = take_reading(
									emspi_pkg::SLOT_VA, emspi_pkg::STRIDE_VA, 1'b1);
								emspi_pkg::ADDR_IRMS: if (rd) r.miso = take_reading(
									emspi_pkg::SLOT_IRMS, emspi_pkg::STRIDE_IRMS, 1'b1);
								emspi_pkg::ADDR_VRMS: if (rd) r.miso = take_reading(
									emspi_pkg::SLOT_VRMS, emspi_pkg::STRIDE_VRMS, 1'b0);
								default:   known = 1'b0;
							endcase
							if (known && rd) begin
								r.load = 1'b1;
								if (sel) begin
									phase = emspi_pkg::PH_REND;
									r.action = wide ? emspi_pkg::ACT_START4 : emspi_pkg::ACT_START2;
								end
							end else if (known && writable) begin
								phase = emspi_pkg::PH_WDATA;
								target = tgt;
								r.action = wide ? emspi_pkg::ACT_START4 : emspi_pkg::ACT_START2;
							end
						end
					end
				end
				default: ;
			endcase
			if (!r.load) r.miso = '0;
			r.relay = relay;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [1:0] act, logic [31:0] miso, logic load, logic rly);
			meter_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: action %0d miso %h load %b relay %b",
					$time, act, miso, load, rly);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (act !== e.action) begin
				$display("%0t transfer_action mismatch: expected %0d actual %0d",
					$time, e.action, act);
				errors++;
			end
			if (miso !== e.miso) begin
				$display("%0t miso_word mismatch: expected %h actual %h", $time, e.miso, miso);
				errors++;
			end
			if (load !== e.load) begin
				$display("%0t miso_load mismatch: expected %b actual %b", $time, e.load, load);
				errors++;
			end
			if (rly !== e.relay) begin
				$display("%0t relay_state mismatch: expected %b actual %b", $time, e.relay, rly);
				errors++;
			end
		endfunction
	endclass

	// every address the slave decodes, for picking well-formed commands
	localparam logic [11:0] KNOWN_ADDR [9] = '{emspi_pkg::ADDR_RUN, emspi_pkg::ADDR_GAIN,
		emspi_pkg::ADDR_DSPCFG, emspi_pkg::ADDR_VERSION, emspi_pkg::ADDR_WATT,
		emspi_pkg::ADDR_VAR, emspi_pkg::ADDR_VA, emspi_pkg::ADDR_IRMS, emspi_pkg::ADDR_VRMS};

	// all block inputs start at a known value
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = emspi_pkg::OP_FRAME;
	logic [31:0] frame_word = '0;
	logic [2:0]  frame_bytes = '0;
	logic        pin_level = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  transfer_action;
	logic [31:0] miso_word;
	logic        miso_load;
	logic        relay_state;

	meter_scoreboard sb;
	int send_idle = 0;
	int recv_idle = 0;
	int sent_count = 0;

	always #5 clk = ~clk;

	energy_meter_spi_register_slave i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.frame_word      (frame_word),
		.frame_bytes     (frame_bytes),
		.pin_level       (pin_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.transfer_action (transfer_action),
		.miso_word       (miso_word),
		.miso_load       (miso_load),
		.relay_state     (relay_state)
	);

	// command frame: address in 31:20, read bit in 19, rest of the word as given
	function automatic logic [31:0] cmd_word(logic [11:0] addr, logic rd, logic [18:0] filler);
		return {addr, rd, filler};
	endfunction

	// present one input transaction, optionally after random idle cycles, and hold it
	// until the slave takes it; the model is told at the accepting edge
	task automatic send_event(input logic [1:0] o, input logic [31:0] w, input logic [2:0] b,
			input logic l);
		while ($urandom_range(99, 0) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		frame_word <= w;
		frame_bytes <= b;
		pin_level <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_event(o, w, b, l);
		sent_count++;
	endtask

	// one complete bus access: select, command, data or read-out end, deselect
	task automatic run_access();
		logic [11:0] addr;
		logic        rd;
		if ($urandom_range(9, 0) == 0) addr = 12'($urandom);
		else addr = KNOWN_ADDR[$urandom_range(8, 0)];
		rd = 1'($urandom);
		send_event(emspi_pkg::OP_CS, $urandom, 3'($urandom), 1'b0);
		send_event(emspi_pkg::OP_FRAME, cmd_word(addr, rd, 19'($urandom)),
			3'($urandom_range(7, 1)), 1'b0);
		send_event(emspi_pkg::OP_FRAME, $urandom, 3'($urandom_range(7, 1)), 1'b0);
		send_event(emspi_pkg::OP_CS, $urandom, 3'($urandom), 1'b1);
	endtask

	// mostly whole accesses, some relay flips, some stray commands and pure noise
	task automatic random_step();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 65)
			run_access();
		else if (pick < 75)
			send_event(emspi_pkg::OP_RELAY, $urandom, 3'($urandom), 1'($urandom));
		else if (pick < 88)
			send_event(emspi_pkg::OP_FRAME, cmd_word(KNOWN_ADDR[$urandom_range(8, 0)],
				1'($urandom), 19'($urandom)), 3'($urandom_range(7, 0)), 1'($urandom));
		else
			send_event(2'($urandom), $urandom, 3'($urandom), 1'($urandom));
	endtask

	// hold the input side off until every predicted result has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	// receiver: check at the accepting edge, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(transfer_action, miso_word, miso_load, relay_state);
			out_ready <= ($urandom_range(99, 0) >= recv_idle);
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first phase of idling applies to the directed part too
		send_idle = 36;
		recv_idle = 46;

		// empty frame and unknown op change nothing
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_WATT, 1'b1, '0), 3'd0, 1'b0);
		send_event(OP_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1);
		// chip select low loads the idle word, high stops
		send_event(emspi_pkg::OP_CS, 32'h0, 3'd0, 1'b0);
		send_event(emspi_pkg::OP_CS, 32'hFFFF_FFFF, 3'd7, 1'b1);
		// version read, selected, then read-out end
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VERSION, 1'b1, '0), 3'd2, 1'b0);
		send_event(emspi_pkg::OP_FRAME, 32'h0, 3'd4, 1'b0);
		// 16-bit writes at the extremes, deselected data frame, then read back
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_RUN, 1'b0, '1), 3'd2, 1'b1);
		send_event(emspi_pkg::OP_FRAME, 32'hFFFF_FFFF, 3'd2, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_GAIN, 1'b0, '0), 3'd2, 1'b0);
		send_event(emspi_pkg::OP_FRAME, 32'h0000_FFFF, 3'd2, 1'b0);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_RUN, 1'b1, '0), 3'd2, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_GAIN, 1'b1, '0), 3'd2, 1'b1);
		// 32-bit write and read back, frame count above four
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_DSPCFG, 1'b0, '0), 3'd4, 1'b0);
		send_event(emspi_pkg::OP_FRAME, 32'hFFFF_FFFF, 3'd7, 1'b0);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_DSPCFG, 1'b1, '0), 3'd5, 1'b0);
		send_event(emspi_pkg::OP_FRAME, 32'h1234_5678, 3'd4, 1'b0);
		// write to the version word: data frame swallowed, no transfer
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VERSION, 1'b0, '0), 3'd4, 1'b0);
		send_event(emspi_pkg::OP_FRAME, 32'hA5A5_5A5A, 3'd4, 1'b0);
		// write command to a measurement and read command to an unknown address are ignored
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_WATT, 1'b0, '0), 3'd2, 1'b0);
		send_event(emspi_pkg::OP_FRAME, cmd_word(12'hFFF, 1'b1, '1), 3'd2, 1'b0);
		// relay on, measurements read while deselected so no read-out phase follows
		send_event(emspi_pkg::OP_RELAY, 32'h0, 3'd0, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_WATT, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VAR, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VA, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_IRMS, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VRMS, 1'b1, '0), 3'd4, 1'b1);
		// relay off: gated readings go to zero, voltage keeps reloading
		send_event(emspi_pkg::OP_RELAY, 32'hFFFF_FFFF, 3'd7, 1'b0);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_IRMS, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_IRMS, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VRMS, 1'b1, '0), 3'd4, 1'b1);
		send_event(emspi_pkg::OP_FRAME, cmd_word(emspi_pkg::ADDR_VRMS, 1'b1, '0), 3'd4, 1'b1);

		// random part in three idling phases; the input side waits for a full drain
		// between phases
		sent_count = 0;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 36;
					recv_idle = 46;
				end
				1: begin
					send_idle = 46;
					recv_idle = 36;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			while (sent_count < (ph + 1) * 270) random_step();
			wait_drained();
		end

		// let the pipeline settle so a stray extra result would show up
		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/emspi_pkg.sv
src/energy_meter_spi_register_slave.sv
test/tb.sv
